FILE: hdl/tprc_pkg.sv
// Shared constants for the tick period rate converter.
package tprc_pkg;
  localparam int TICK_BITS_DEF = 16;
  localparam int TICKS_W = 16;
  localparam int SCALE_W = 26;
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;

  localparam logic [1:0] CMD_RPM  = 2'd0;
  localparam logic [1:0] CMD_HZ   = 2'd1;
  localparam logic [1:0] CMD_MS   = 2'd2;
  localparam logic [1:0] CMD_USEC = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] K_RPM_NUM  = 32'd60000000;
  localparam logic [31:0] K_HZ_NUM   = 32'd1000000;
  localparam logic [16:0] K_USEC_MUL = 17'd100000;
  localparam logic [9:0]  K_MS_MUL   = 10'd1000;
  localparam logic [31:0] MAX32      = 32'hFFFFFFFF;
endpackage

FILE: hdl/tprc_div.sv
// Pipelined restoring divider, one quotient bit per stage, payload alongside.
module tprc_div import tprc_pkg::*; #(
  parameter int NW = 49,
  parameter int DW = 32,
  parameter int PW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);
  logic          vld_r [NW+1];
  logic [NW-1:0] num_r [NW+1];
  logic [DW-1:0] den_r [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [PW-1:0] pay_r [NW+1];

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    den_r[0] = in_den;
    rem_r[0] = '0;
    pay_r[0] = in_pay;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW+1:0] sub;
    logic [NW-1:0] shifted;
    logic          nb;
    always_comb begin
      trial = {rem_r[s], num_r[s][NW-1]};
      sub = trial - {2'b00, den_r[s]};
      nb = !sub[DW+1];
      shifted = {num_r[s][NW-2:0], nb};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (en) begin
        num_r[s+1] <= shifted;
        den_r[s+1] <= den_r[s];
        rem_r[s+1] <= nb ? sub[DW:0] : trial[DW:0];
        pay_r[s+1] <= pay_r[s];
      end
    end
  end

  assign out_vld = vld_r[NW];
  assign out_quo = num_r[NW];
  assign out_pay = pay_r[NW];
endmodule

FILE: hdl/tick_period_rate_converter.sv
// Top level of the tick period rate converter.
// Usage:
//   Input request: in_cmd, in_timer_ticks, in_tick_scaling with
//   in_valid/in_ready. Result request: out_value, out_status with
//   out_valid/out_ready. One result per request, in order.
// Pipeline:
//   stage 0 registers the request, stage 1 estimates scaling/10 by a
//   reciprocal multiply, stage 2 corrects that estimate and forms the ticks
//   products, then a first divider gives the usec or ms quotient one bit per
//   stage, a check stage saturates, a second divider forms 60e6/u or 1e6/u,
//   and a final stage picks the value into the output register.
// Throughput: one request per cycle while the pipeline is not stalled; the
//   latency from the accepting edge to out_valid is set mainly by the two
//   bit-serial divider pipelines (TICK_BITS+17 = 33 and 32 stages).
// Stall: the whole pipeline advances only when the output register is
//   empty or being taken, so in_ready = !out_valid || out_ready; nothing is
//   dropped or repeated.
// Reset: synchronous active-low rst_n clears all valid bits; the block is
//   stateless across requests.
module tick_period_rate_converter import tprc_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [TICKS_W-1:0]  in_timer_ticks,
  input  logic [SCALE_W-1:0]  in_tick_scaling,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  out_value,
  output logic [STATUS_W-1:0] out_status
);
  localparam int NW = TICK_BITS + 17; // ticks*100000 width
  localparam int PW = 2 + 1;          // cmd, div0

  typedef struct packed {
    logic [1:0] cmd;
    logic       div0;
  } pay_t;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0
  logic s0_vld_r;
  logic [1:0] s0_cmd_r;
  logic [TICK_BITS-1:0] s0_tk_r;
  logic [SCALE_W-1:0] s0_sc_r;
  logic [TICK_BITS-1:0] tk_in;
  always_comb begin
    tk_in = '0;
    for (int i = 0; i < TICK_BITS; i++) begin
      if (i < TICKS_W) tk_in[i] = in_timer_ticks[i];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_valid;
    if (en) begin
      s0_cmd_r <= in_cmd;
      s0_tk_r <= tk_in;
      s0_sc_r <= in_tick_scaling;
    end
  end

  // stage 1: scaling/10 estimate, low by at most one
  logic [SCALE_W+26:0] recip;
  logic [SCALE_W-1:0] q10;
  always_comb begin
    recip = {1'b0, s0_sc_r} * 27'd6710886; // floor(2^26/10)
    q10 = recip[SCALE_W+25:26];
  end
  logic sa_vld_r;
  logic [1:0] sa_cmd_r;
  logic [TICK_BITS-1:0] sa_tk_r;
  logic [SCALE_W-1:0] sa_sc_r;
  logic [SCALE_W-1:0] sa_q10_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sa_vld_r <= 1'b0;
    else if (en) sa_vld_r <= s0_vld_r;
    if (en) begin
      sa_cmd_r <= s0_cmd_r;
      sa_tk_r <= s0_tk_r;
      sa_sc_r <= s0_sc_r;
      sa_q10_r <= q10;
    end
  end

  // stage 2: correct scaling/10, products
  logic [SCALE_W-1:0] q10c;
  logic [SCALE_W+3:0] back;
  always_comb begin
    back = {4'd0, sa_q10_r} * 30'd10;
    q10c = ({4'd0, sa_sc_r} - back >= 30'd10) ? sa_q10_r + 1'b1 : sa_q10_r;
  end
  logic s1_vld_r;
  pay_t s1_pay_r;
  logic [NW-1:0] s1_num_r;
  logic [31:0] s1_den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= sa_vld_r;
    if (en) begin
      s1_pay_r.cmd <= sa_cmd_r;
      if (sa_cmd_r == CMD_MS) begin
        s1_num_r <= NW'(sa_tk_r) * NW'(K_MS_MUL);
        s1_den_r <= 32'(sa_sc_r);
        s1_pay_r.div0 <= (sa_sc_r == '0);
      end else begin
        s1_num_r <= NW'(sa_tk_r) * NW'(K_USEC_MUL);
        s1_den_r <= 32'(q10c);
        s1_pay_r.div0 <= (q10c == '0);
      end
    end
  end

  logic d1_vld;
  logic [NW-1:0] d1_q;
  pay_t d1_pay;
  tprc_div #(.NW(NW), .DW(32), .PW(PW)) u_div1 (
    .clk, .rst_n, .en, .in_vld(s1_vld_r), .in_num(s1_num_r),
    .in_den(s1_den_r), .in_pay(s1_pay_r), .out_vld(d1_vld),
    .out_quo(d1_q), .out_pay(d1_pay)
  );

  // check stage: saturation and the first value
  logic s2_vld_r;
  logic [1:0] s2_cmd_r, s2_st_r;
  logic [31:0] s2_u_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= d1_vld;
    if (en) begin
      s2_cmd_r <= d1_pay.cmd;
      if (d1_pay.div0) begin
        s2_u_r <= '0;
        s2_st_r <= ST_DIV0;
      end else if ((d1_q >> 32) != '0) begin
        s2_u_r <= MAX32;
        s2_st_r <= ST_SAT;
      end else begin
        s2_u_r <= d1_q[31:0];
        s2_st_r <= ST_OK;
      end
    end
  end

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  st;
    logic [31:0] u;
  } pay2_t;
  pay2_t p2_in, p2_out;
  logic d2_vld;
  logic [31:0] d2_q;
  assign p2_in = '{cmd: s2_cmd_r, st: s2_st_r, u: s2_u_r};
  tprc_div #(.NW(32), .DW(32), .PW(36)) u_div2 (
    .clk, .rst_n, .en, .in_vld(s2_vld_r),
    .in_num(s2_cmd_r == CMD_RPM ? K_RPM_NUM : K_HZ_NUM),
    .in_den(s2_u_r), .in_pay(p2_in), .out_vld(d2_vld),
    .out_quo(d2_q), .out_pay(p2_out)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= d2_vld;
    if (en) begin
      if (p2_out.cmd == CMD_MS || p2_out.cmd == CMD_USEC) begin
        out_value <= p2_out.u;
        out_status <= p2_out.st;
      end else if (p2_out.st == ST_DIV0 || p2_out.u == '0) begin
        out_value <= '0;
        out_status <= ST_DIV0;
      end else begin
        out_value <= d2_q;
        out_status <= p2_out.st;
      end
    end
  end
endmodule

FILE: hdl/tprc_checker.sv
// Port-level checks for the tick period rate converter, with bind.
module tprc_checker import tprc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_status
);
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped");
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV0 |-> out_value == '0)
    else $error("div0 value");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
endmodule

bind tick_period_rate_converter tprc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_value, .out_status
);
